// ===== hw/rtl/bvc_pkg.sv =====
// Shared types, constants and letter tables for the bilingual Vigenere cipher.
// No dependencies; every other file takes its names from here by scoped reference.
package bvc_pkg;

   localparam int MAX_KEY_DEFAULT = 64;
   localparam int CHAR_W          = 16;
   localparam int SHIFT_W         = 6;
   localparam int LEN_W           = 6;

   localparam logic [LEN_W-1:0] ENG_LEN = LEN_W'(26);
   localparam logic [LEN_W-1:0] RUS_LEN = LEN_W'(33);

   // Item operation codes
   localparam logic OP_KEY  = 1'b0;
   localparam logic OP_TEXT = 1'b1;

   // Direction register codes
   localparam logic DIR_ENCRYPT = 1'b0;
   localparam logic DIR_DECRYPT = 1'b1;

   // Code points
   localparam logic [CHAR_W-1:0] ENG_UP_A   = 16'h0041;
   localparam logic [CHAR_W-1:0] ENG_UP_Z   = 16'h005A;
   localparam logic [CHAR_W-1:0] ENG_LO_A   = 16'h0061;
   localparam logic [CHAR_W-1:0] ENG_LO_Z   = 16'h007A;
   localparam logic [CHAR_W-1:0] RUS_UP_A   = 16'h0410;
   localparam logic [CHAR_W-1:0] RUS_UP_YA  = 16'h042F;
   localparam logic [CHAR_W-1:0] RUS_UP_YO  = 16'h0401;
   localparam logic [CHAR_W-1:0] RUS_LO_A   = 16'h0430;
   localparam logic [CHAR_W-1:0] RUS_LO_YA  = 16'h044F;
   localparam logic [CHAR_W-1:0] RUS_LO_YO  = 16'h0451;
   // YO sits at this place in the alphabet, between YE and ZHE
   localparam logic [SHIFT_W-1:0] RUS_YO_IDX = SHIFT_W'(6);

   typedef enum logic [2:0] {
      CLS_NONE,
      CLS_ENG_UP,
      CLS_ENG_LO,
      CLS_RUS_UP,
      CLS_RUS_LO
   } alpha_class_type;

   typedef struct packed {
      alpha_class_type       cls;
      logic [SHIFT_W-1:0]    idx;
   } letter_info_type;

   // Map a code unit onto its alphabet and index within it
   function automatic letter_info_type classify(input logic [CHAR_W-1:0] c);
      letter_info_type    r;
      logic [SHIFT_W-1:0] off;
      r.cls = CLS_NONE;
      r.idx = '0;
      off   = '0;
      priority if (c >= ENG_UP_A && c <= ENG_UP_Z) begin
         r.cls = CLS_ENG_UP;
         r.idx = SHIFT_W'(c - ENG_UP_A);
      end else if (c >= ENG_LO_A && c <= ENG_LO_Z) begin
         r.cls = CLS_ENG_LO;
         r.idx = SHIFT_W'(c - ENG_LO_A);
      end else if (c == RUS_UP_YO) begin
         r.cls = CLS_RUS_UP;
         r.idx = RUS_YO_IDX;
      end else if (c >= RUS_UP_A && c <= RUS_UP_YA) begin
         r.cls = CLS_RUS_UP;
         off   = SHIFT_W'(c - RUS_UP_A);
         r.idx = (off >= RUS_YO_IDX) ? off + SHIFT_W'(1) : off;
      end else if (c == RUS_LO_YO) begin
         r.cls = CLS_RUS_LO;
         r.idx = RUS_YO_IDX;
      end else if (c >= RUS_LO_A && c <= RUS_LO_YA) begin
         r.cls = CLS_RUS_LO;
         off   = SHIFT_W'(c - RUS_LO_A);
         r.idx = (off >= RUS_YO_IDX) ? off + SHIFT_W'(1) : off;
      end else begin
         r.cls = CLS_NONE;
      end
      return r;
   endfunction

   // Rebuild a code unit from alphabet and index
   function automatic logic [CHAR_W-1:0] letter_at(input alpha_class_type cls,
                                                 input logic [SHIFT_W-1:0] idx);
      logic [CHAR_W-1:0] base;
      logic [CHAR_W-1:0] yo;
      logic [CHAR_W-1:0] code;
      base = ENG_UP_A;
      yo   = RUS_UP_YO;
      code = '0;
      unique case (cls)
         CLS_ENG_UP: base = ENG_UP_A;
         CLS_ENG_LO: base = ENG_LO_A;
         CLS_RUS_UP: begin
            base = RUS_UP_A;
            yo   = RUS_UP_YO;
         end
         CLS_RUS_LO: begin
            base = RUS_LO_A;
            yo   = RUS_LO_YO;
         end
         default:    base = ENG_UP_A;
      endcase
      if (cls == CLS_RUS_UP || cls == CLS_RUS_LO) begin
         priority if (idx < RUS_YO_IDX) begin
            code = base + CHAR_W'(idx);
         end else if (idx == RUS_YO_IDX) begin
            code = yo;
         end else begin
            code = base + CHAR_W'(idx) - CHAR_W'(1);
         end
      end else begin
         code = base + CHAR_W'(idx);
      end
      return code;
   endfunction

endpackage

// ===== hw/rtl/bvc_req_if.sv =====
// Request channel carrying key and text items into the cipher.
// Depends on bvc_pkg for the code unit width.
interface bvc_req_if;
   logic                        valid;
   logic                        ready;
   logic                        operation;
   logic [bvc_pkg::CHAR_W-1:0]  char_code;
   logic                        restart;

   modport source (output valid, output operation, output char_code, output restart,
                   input ready);
   modport sink   (input valid, input operation, input char_code, input restart,
                   output ready);
endinterface

// ===== hw/rtl/bvc_rsp_if.sv =====
// Response channel carrying ciphered text items out of the cipher.
// Depends on bvc_pkg for the code unit width.
interface bvc_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [bvc_pkg::CHAR_W-1:0]  out_char;
   logic                        ciphered;

   modport source (output valid, output out_char, output ciphered, input ready);
   modport sink   (input valid, input out_char, input ciphered, output ready);
endinterface

// ===== hw/rtl/bilingual_vigenere_cipher.sv =====
// Streaming Vigenere cipher over UTF-16 code units, English and Russian alphabets.
// Depends on bvc_pkg, bvc_req_if and bvc_rsp_if.
//
// Usage:
//   req_ch  - items in. operation selects a key character (stored as a shift) or
//             a text character (ciphered). restart clears the key on a key item
//             and rewinds the key position on a text item.
//   rsp_ch  - one item out per text item: out_char and the ciphered flag. Key
//             items give nothing out.
//   csr_*   - direction register (0 encrypt, 1 decrypt); write only while idle.
// Timing:
//   A text item passes from the lookup stage into the output register and then
//   out on rsp_ch. Throughput is one item per cycle unless rsp_ch stalls; the
//   key store is a single-port memory read once per text item and written once
//   per stored key letter, and the key counters advance at acceptance, so items
//   follow back to back with no bubble.
// Reset:
//   Clears the key count, key position, direction and both pipeline valids.
//   The key store itself is not cleared; only entries below the count are used.
// Back-pressure:
//   When rsp_ch stalls the result holds in the output register; one more text
//   item may wait in the lookup stage, after which req_ch.ready drops.
module bilingual_vigenere_cipher #(
   parameter int MAX_KEY = bvc_pkg::MAX_KEY_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   bvc_req_if.sink       req_ch,
   bvc_rsp_if.source     rsp_ch,
   input  logic          csr_wr_en,
   input  logic          csr_wr_data
);

   localparam int AW = (MAX_KEY > 1) ? $clog2(MAX_KEY) : 1;
   localparam int CW = $clog2(MAX_KEY + 1);
   localparam logic [CW-1:0] KEY_CAP = CW'(MAX_KEY);

   // Key shift store: one entry per key letter
   logic [bvc_pkg::SHIFT_W-1:0] key_mem [MAX_KEY];

   logic [CW-1:0]               key_count_ff, key_count_in;
   logic [AW-1:0]               key_pos_ff, key_pos_in;
   logic                        direction_ff, direction_in;

   // Lookup stage: holds the text item while the shift is read
   logic                        s1_valid_ff, s1_valid_in;
   logic [bvc_pkg::CHAR_W-1:0]  s1_char_ff;
   bvc_pkg::alpha_class_type    s1_cls_ff;
   logic [bvc_pkg::SHIFT_W-1:0] s1_idx_ff;
   logic                        s1_live_ff;
   logic [bvc_pkg::SHIFT_W-1:0] rd_shift_ff;

   // Output register
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [bvc_pkg::CHAR_W-1:0]  rsp_char_ff;
   logic                        rsp_ciph_ff;

   logic                        out_free, s1_move, acc, acc_key, acc_text;
   bvc_pkg::letter_info_type    info;
   logic                        is_letter, key_wr;
   logic [CW-1:0]               count_base;
   logic [AW-1:0]               pos_base, pos_rd;
   logic [CW-1:0]               pos_next;

   logic [bvc_pkg::LEN_W-1:0]   len;
   logic [bvc_pkg::LEN_W-1:0]   shift;
   logic [bvc_pkg::LEN_W:0]     raw;
   logic [bvc_pkg::LEN_W-1:0]   new_idx;
   logic [bvc_pkg::CHAR_W-1:0]  out_char_c;

   // ---------------------------------------------------------------- handshake
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign s1_move      = s1_valid_ff && out_free;
   assign req_ch.ready = !s1_valid_ff || out_free;
   assign acc          = req_ch.valid && req_ch.ready;
   assign acc_key      = acc && (req_ch.operation == bvc_pkg::OP_KEY);
   assign acc_text     = acc && (req_ch.operation == bvc_pkg::OP_TEXT);

   // ---------------------------------------------------------------- accept stage
   always_comb begin
      info       = bvc_pkg::classify(req_ch.char_code);
      is_letter  = (info.cls != bvc_pkg::CLS_NONE);
      // restart on a key item empties the key before this letter is stored
      count_base = req_ch.restart ? '0 : key_count_ff;
      key_wr     = acc_key && is_letter && (count_base < KEY_CAP);
      // restart on a text item rewinds the key position
      pos_base   = req_ch.restart ? '0 : key_pos_ff;
      pos_rd     = (CW'(pos_base) < key_count_ff) ? pos_base : '0;
      pos_next   = CW'(pos_rd) + CW'(1);

      key_count_in = key_count_ff;
      key_pos_in   = key_pos_ff;
      if (acc_key) begin
         key_count_in = key_wr ? count_base + CW'(1) : count_base;
         if (req_ch.restart) begin
            key_pos_in = '0;
         end
      end else if (acc_text) begin
         if (is_letter && key_count_ff != '0) begin
            // advance cyclically past each ciphered letter
            key_pos_in = (pos_next >= key_count_ff) ? '0 : pos_next[AW-1:0];
         end else begin
            key_pos_in = pos_base;
         end
      end
   end

   assign direction_in = csr_wr_en ? csr_wr_data : direction_ff;

   // Key store: write on a stored key letter, read on every text item
   always_ff @(posedge clock) begin
      if (key_wr) begin
         key_mem[count_base[AW-1:0]] <= info.idx;
      end
      if (acc_text) begin
         rd_shift_ff <= key_mem[pos_rd];
      end
   end

   // ---------------------------------------------------------------- shift stage
   always_comb begin
      len = (s1_cls_ff == bvc_pkg::CLS_ENG_UP || s1_cls_ff == bvc_pkg::CLS_ENG_LO) ?
            bvc_pkg::ENG_LEN : bvc_pkg::RUS_LEN;
      // a Russian key letter can exceed the English alphabet: fold it once
      shift = (rd_shift_ff >= len) ? rd_shift_ff - len : rd_shift_ff;
      if (direction_ff == bvc_pkg::DIR_DECRYPT) begin
         raw = {1'b0, s1_idx_ff} + {1'b0, len} - {1'b0, shift};
      end else begin
         raw = {1'b0, s1_idx_ff} + {1'b0, shift};
      end
      new_idx    = (raw >= {1'b0, len}) ? bvc_pkg::LEN_W'(raw - {1'b0, len})
                                        : raw[bvc_pkg::LEN_W-1:0];
      out_char_c = s1_live_ff ? bvc_pkg::letter_at(s1_cls_ff, new_idx) : s1_char_ff;
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (acc_text) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s1_move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         key_count_ff <= '0;
         key_pos_ff   <= '0;
         direction_ff <= bvc_pkg::DIR_ENCRYPT;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         key_count_ff <= key_count_in;
         key_pos_ff   <= key_pos_in;
         direction_ff <= direction_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers: load on accept or on a move to output, hold otherwise
   always_ff @(posedge clock) begin
      if (acc_text) begin
         s1_char_ff <= req_ch.char_code;
         s1_cls_ff  <= info.cls;
         s1_idx_ff  <= info.idx;
         s1_live_ff <= is_letter && (key_count_ff != '0);
      end
      if (s1_move) begin
         rsp_char_ff <= out_char_c;
         rsp_ciph_ff <= s1_live_ff;
      end
   end

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.out_char = rsp_char_ff;
   assign rsp_ch.ciphered = rsp_ciph_ff;

endmodule

// ===== bench/tb.sv =====
// Self-checking bench for the bilingual Vigenere cipher: a directed script,
// then random key and text streams checked against a predictor of its own.
// Depends on bvc_pkg, bvc_req_if, bvc_rsp_if and bilingual_vigenere_cipher.
`timescale 1ns / 100ps

module tb;

   localparam int KEY_DEPTH  = bvc_pkg::MAX_KEY_DEFAULT;
   localparam int IDLE_PCT   = 34;
   localparam int DRAIN_GAP  = 4;     // pipeline is two stages deep
   localparam int STALL_MAX  = 1000;  // cycles with no item moving on either side
   localparam int PHASES     = 6;
   localparam int PHASE_ITEMS = 50;

   // Russian capitals in alphabet order; YO follows YE
   localparam logic [15:0] CYR_UP [0:32] = '{
      16'h0410, 16'h0411, 16'h0412, 16'h0413, 16'h0414, 16'h0415, 16'h0401, 16'h0416,
      16'h0417, 16'h0418, 16'h0419, 16'h041A, 16'h041B, 16'h041C, 16'h041D, 16'h041E,
      16'h041F, 16'h0420, 16'h0421, 16'h0422, 16'h0423, 16'h0424, 16'h0425, 16'h0426,
      16'h0427, 16'h0428, 16'h0429, 16'h042A, 16'h042B, 16'h042C, 16'h042D, 16'h042E,
      16'h042F
   };

   // Code units sitting just outside the four alphabets, plus a few far from them
   localparam logic [15:0] EDGE_CODES [0:11] = '{
      16'h0000, 16'h0040, 16'h005B, 16'h0060, 16'h007B, 16'h0400,
      16'h0402, 16'h040F, 16'h0450, 16'h0452, 16'h0460, 16'hFFFF
   };

   typedef struct packed {
      logic [15:0] ch;
      logic        ciph;
   } glyph_type;

   typedef enum logic [1:0] {
      ROW_KEY,
      ROW_TEXT,
      ROW_DIR
   } row_kind_type;

   typedef struct packed {
      row_kind_type kind;
      logic [15:0]  code;
      logic         rst;
      logic         typed;
      glyph_type    want;
   } script_row_type;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic csr_wr_data;

   bvc_req_if req_ch ();
   bvc_rsp_if rsp_ch ();

   bilingual_vigenere_cipher DUT (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Predictor state: stored key shifts, key length and position, direction
   logic [5:0]  key_store [KEY_DEPTH];
   int unsigned key_len;
   int unsigned key_pos;
   logic        dir_q;

   glyph_type glyphs_due [$];   // ciphered characters still owed by the block
   int        errors = 0;
   int        idle_run = 0;
   bit        no_idle;

   // Directed script. Expectations are typed in only where they are obvious:
   // empty key, non-letters, single-letter keys with a plain wrap.
   script_row_type script_rows [25] = '{
      // empty key after reset: everything passes through
      '{ROW_TEXT, 16'h0041, 1'b0, 1'b1, '{16'h0041, 1'b0}},
      '{ROW_TEXT, 16'hFFFF, 1'b0, 1'b1, '{16'hFFFF, 1'b0}},
      '{ROW_TEXT, 16'h0000, 1'b1, 1'b1, '{16'h0000, 1'b0}},
      // non-letter key character is dropped, key stays empty
      '{ROW_KEY,  16'h0000, 1'b0, 1'b0, '0},
      '{ROW_TEXT, 16'h005A, 1'b0, 1'b1, '{16'h005A, 1'b0}},
      // key "B": Z wraps to A, a goes to b
      '{ROW_KEY,  16'h0042, 1'b1, 1'b0, '0},
      '{ROW_TEXT, 16'h005A, 1'b0, 1'b1, '{16'h0041, 1'b1}},
      '{ROW_TEXT, 16'h0061, 1'b0, 1'b1, '{16'h0062, 1'b1}},
      '{ROW_TEXT, 16'h0020, 1'b0, 1'b1, '{16'h0020, 1'b0}},
      // Russian YA as key: shift of 32 exceeds the English alphabet
      '{ROW_KEY,  16'h042F, 1'b1, 1'b0, '0},
      '{ROW_TEXT, 16'h0041, 1'b0, 1'b1, '{16'h0047, 1'b1}},
      '{ROW_TEXT, 16'h0401, 1'b0, 1'b1, '{16'h0415, 1'b1}},
      // append to the key, then rewind the position on a text item
      '{ROW_KEY,  16'h0061, 1'b0, 1'b0, '0},
      '{ROW_KEY,  16'h0451, 1'b0, 1'b0, '0},
      '{ROW_TEXT, 16'h044F, 1'b1, 1'b0, '0},
      '{ROW_TEXT, 16'h007A, 1'b0, 1'b0, '0},
      '{ROW_TEXT, 16'h0410, 1'b0, 1'b0, '0},
      // restart with a non-letter leaves the key empty
      '{ROW_KEY,  16'hFFFF, 1'b1, 1'b0, '0},
      '{ROW_TEXT, 16'h004D, 1'b0, 1'b1, '{16'h004D, 1'b0}},
      // decrypt with key "D": A wraps back to X
      '{ROW_DIR,  16'(bvc_pkg::DIR_DECRYPT), 1'b0, 1'b0, '0},
      '{ROW_KEY,  16'h0044, 1'b1, 1'b0, '0},
      '{ROW_TEXT, 16'h0041, 1'b0, 1'b1, '{16'h0058, 1'b1}},
      '{ROW_TEXT, 16'h0430, 1'b0, 1'b0, '0},
      '{ROW_TEXT, 16'h0451, 1'b0, 1'b0, '0},
      '{ROW_TEXT, 16'h0401, 1'b1, 1'b0, '0}
   };

   function automatic logic [15:0] cyr_lower(input int unsigned at);
      return CYR_UP[at] + ((at == 6) ? 16'h0050 : 16'h0020);
   endfunction

   // Find the alphabet of a code unit and its place in it
   function automatic bvc_pkg::alpha_class_type sort_letter(input logic [15:0] c,
                                                            output int unsigned at);
      at = 0;
      if (c >= bvc_pkg::ENG_UP_A && c <= bvc_pkg::ENG_UP_Z) begin
         at = c - bvc_pkg::ENG_UP_A;
         return bvc_pkg::CLS_ENG_UP;
      end
      if (c >= bvc_pkg::ENG_LO_A && c <= bvc_pkg::ENG_LO_Z) begin
         at = c - bvc_pkg::ENG_LO_A;
         return bvc_pkg::CLS_ENG_LO;
      end
      for (int i = 0; i < 33; i++) begin
         if (c == CYR_UP[i]) begin
            at = i;
            return bvc_pkg::CLS_RUS_UP;
         end
         if (c == cyr_lower(i)) begin
            at = i;
            return bvc_pkg::CLS_RUS_LO;
         end
      end
      return bvc_pkg::CLS_NONE;
   endfunction

   function automatic logic [15:0] code_of(input bvc_pkg::alpha_class_type cls,
                                           input int unsigned at);
      case (cls)
         bvc_pkg::CLS_ENG_UP: return bvc_pkg::ENG_UP_A + 16'(at);
         bvc_pkg::CLS_ENG_LO: return bvc_pkg::ENG_LO_A + 16'(at);
         bvc_pkg::CLS_RUS_UP: return CYR_UP[at];
         default:             return cyr_lower(at);
      endcase
   endfunction

   // Advance the predictor by one accepted item; return 1 where a result is owed
   function automatic bit cipher_step(input logic op, input logic [15:0] c, input logic rst,
                                      output glyph_type res);
      bvc_pkg::alpha_class_type cls;
      int unsigned              at;
      int unsigned              span;
      int unsigned              shift;
      int unsigned              slot;
      res.ch   = c;
      res.ciph = 1'b0;
      cls      = sort_letter(c, at);
      if (op == bvc_pkg::OP_KEY) begin
         if (rst) begin
            key_len = 0;
            key_pos = 0;
         end
         // letters beyond capacity and non-letters leave the key alone
         if (cls != bvc_pkg::CLS_NONE && key_len < KEY_DEPTH) begin
            key_store[key_len] = 6'(at);
            key_len++;
         end
         return 1'b0;
      end
      if (rst) key_pos = 0;
      if (cls == bvc_pkg::CLS_NONE || key_len == 0) return 1'b1;
      span  = (cls == bvc_pkg::CLS_ENG_UP || cls == bvc_pkg::CLS_ENG_LO) ? 26 : 33;
      slot  = (key_pos < key_len) ? key_pos : 0;
      shift = key_store[slot] % span;
      if (dir_q == bvc_pkg::DIR_DECRYPT) at = (at + span - shift) % span;
      else                               at = (at + shift) % span;
      slot++;
      key_pos  = (slot >= key_len) ? 0 : slot;
      res.ch   = code_of(cls, at);
      res.ciph = 1'b1;
      return 1'b1;
   endfunction

   // Random character: mostly letters, unless letters_only the odd edge or wild code
   function automatic logic [15:0] pick_char(input bit letters_only);
      int unsigned sel;
      sel = letters_only ? $urandom_range(6) : $urandom_range(9);
      case (sel)
         0, 1:    return bvc_pkg::ENG_UP_A + 16'($urandom_range(25));
         2:       return bvc_pkg::ENG_LO_A + 16'($urandom_range(25));
         3, 4:    return CYR_UP[$urandom_range(32)];
         5, 6:    return cyr_lower($urandom_range(32));
         7:       return EDGE_CODES[$urandom_range(11)];
         default: return 16'($urandom_range(16'hFFFF));
      endcase
   endfunction

   // Clock: 10 ns period
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Result side back-pressure: drop ready about a third of the time unless no_idle
   always @(negedge clock) begin
      rsp_ch.ready <= no_idle ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
   end

   // Compare each result with the oldest owed character
   always @(posedge clock) begin
      glyph_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (glyphs_due.size() == 0) begin
            $error("unexpected item: out_char %h ciphered %b", rsp_ch.out_char,
                   rsp_ch.ciphered);
            errors++;
         end else begin
            want = glyphs_due.pop_front();
            if (rsp_ch.out_char !== want.ch) begin
               $error("out_char: expected %h, got %h", want.ch, rsp_ch.out_char);
               errors++;
            end
            if (rsp_ch.ciphered !== want.ciph) begin
               $error("ciphered: expected %b, got %b", want.ciph, rsp_ch.ciphered);
               errors++;
            end
         end
      end
   end

   // Watchdog: end the run once nothing has moved for too long
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_run = 0;
      end else begin
         idle_run++;
         if (idle_run >= STALL_MAX) begin
            $display("watchdog: no item moved for %0d cycles", STALL_MAX);
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   // Offer one item, hold it until taken, then book the owed result
   task automatic send_item(input logic op, input logic [15:0] c, input logic rst,
                            input logic typed, input glyph_type typed_res);
      glyph_type res;
      bit        owed;
      while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.operation <= op;
      req_ch.char_code <= c;
      req_ch.restart   <= rst;
      do @(posedge clock); while (!req_ch.ready);
      owed = cipher_step(op, c, rst, res);
      if (owed) glyphs_due.push_back(typed ? typed_res : res);
      @(negedge clock);
   endtask

   // Hold the sender until every owed result is back and the pipeline is empty
   task automatic hold_until_drained();
      req_ch.valid <= 1'b0;
      while (glyphs_due.size() != 0) @(negedge clock);
      repeat (DRAIN_GAP) @(negedge clock);
   endtask

   task automatic set_direction(input logic d);
      hold_until_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= d;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      dir_q = d;
   endtask

   initial begin
      int unsigned              taken;
      int unsigned              span_len;
      int unsigned              dummy;
      logic [15:0]              c;
      logic                     rst;
      bit                       paused;
      bvc_pkg::alpha_class_type cls;

      // Drive the request and control inputs to known values and hold reset
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.operation = bvc_pkg::OP_KEY;
      req_ch.char_code = '0;
      req_ch.restart   = 1'b0;
      csr_wr_en        = 1'b0;
      csr_wr_data      = bvc_pkg::DIR_ENCRYPT;
      no_idle          = 1'b0;
      paused           = 1'b0;
      key_len          = 0;
      key_pos          = 0;
      dir_q            = bvc_pkg::DIR_ENCRYPT;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed script
      foreach (script_rows[i]) begin
         case (script_rows[i].kind)
            ROW_DIR:  set_direction(script_rows[i].code[0]);
            ROW_KEY:  send_item(bvc_pkg::OP_KEY, script_rows[i].code, script_rows[i].rst,
                                1'b0, '0);
            default:  send_item(bvc_pkg::OP_TEXT, script_rows[i].code, script_rows[i].rst,
                                script_rows[i].typed, script_rows[i].want);
         endcase
      end

      // Random phases, direction alternating; one phase runs with no idling at all
      for (int phase = 0; phase < PHASES; phase++) begin
         set_direction((phase % 2) ? bvc_pkg::DIR_DECRYPT : bvc_pkg::DIR_ENCRYPT);
         no_idle = (phase == 3);
         taken   = 0;
         while (taken < PHASE_ITEMS) begin
            // once, mid-phase, hold off until the block has caught up
            if (phase == 2 && taken > 30 && !paused) begin
               hold_until_drained();
               paused = 1'b1;
            end
            if ($urandom_range(99) < 85) begin
               // well-formed: a fresh key (at times long, may pass capacity), then text
               span_len = ($urandom_range(9) == 0) ? $urandom_range(70, 60)
                                                   : $urandom_range(8, 1);
               for (int k = 0; k < span_len; k++) begin
                  c   = pick_char($urandom_range(9) != 0);
                  rst = (k == 0) && ($urandom_range(9) != 0);
                  send_item(bvc_pkg::OP_KEY, c, rst, 1'b0, '0);
                  cls = sort_letter(c, dummy);
                  if (cls != bvc_pkg::CLS_NONE) taken++;
               end
               span_len = $urandom_range(20, 1);
               for (int k = 0; k < span_len; k++) begin
                  send_item(bvc_pkg::OP_TEXT, pick_char(1'b0), $urandom_range(9) == 0,
                            1'b0, '0);
                  taken++;
               end
            end else begin
               // noise: raw fields with no structure
               span_len = $urandom_range(5, 1);
               for (int k = 0; k < span_len; k++) begin
                  c   = 16'($urandom_range(16'hFFFF));
                  rst = $urandom_range(1);
                  if ($urandom_range(1)) begin
                     send_item(bvc_pkg::OP_TEXT, c, rst, 1'b0, '0);
                     taken++;
                  end else begin
                     send_item(bvc_pkg::OP_KEY, c, rst, 1'b0, '0);
                  end
               end
            end
         end
      end

      // Drain, let the pipeline settle, then report
      no_idle = 1'b0;
      hold_until_drained();
      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
